/* hw/rtl/cda_pkg.sv */
// Shared types, constants and calendar helper functions of the date unit.
`default_nettype none
package cda_pkg;

    // Largest year the year fields can carry
    localparam int unsigned YEAR_FIELD_MAX = 16383;
    // Saturation bound of the signed day count
    localparam logic [23:0] COUNT_MAX = 24'd4194303;

    // Request modes
    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_DIFF = 2'd1;
    localparam logic [1:0] MODE_DOY  = 2'd2;
    localparam logic [1:0] MODE_DATE = 2'd3;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_DOY, ST_ADD, ST_YEARS, ST_SPLIT_INIT, ST_SPLIT,
        ST_SERIAL, ST_SAVE_A, ST_FINISH
    } t_state;

    // Datapath commands
    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_CHECK, CMD_DOY_STEP, CMD_ADD_CNT, CMD_YEAR_STEP,
        CMD_SPLIT_INIT, CMD_SPLIT_STEP, CMD_SERIAL, CMD_SAVE_A, CMD_FINISH
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
    } t_ctrl;

    typedef struct packed {
        logic [1:0] mode;
        logic       chk_ok;
        logic       doy_done;
        logic       year_done;
        logic       year_over;
        logic       split_done;
        logic       second;
        logic       out_free;
    } t_stat;

    // Leap year test; y/100 by reciprocal multiply (exact below 32768)
    function automatic logic is_leap(input logic [14:0] y);
        logic [14:0] q;
        logic [14:0] r;
        q = 15'((32'(y) * 32'd5243) >> 19);
        r = 15'(32'(y) - 32'(q) * 32'd100);
        return (y[1:0] == 2'd0) && ((r != 15'd0) || (q[1:0] == 2'd0));
    endfunction

    // Month length, zero for a month code outside 1..12
    function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic [14:0] y);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                  len = 5'd30;
            4'd2:                                      len = is_leap(y) ? 5'd29 : 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_in_year(input logic [14:0] y);
        return is_leap(y) ? 9'd366 : 9'd365;
    endfunction

    // Days before 1 January of year y, counted from year 1
    function automatic logic [23:0] serial_base(input logic [13:0] y);
        logic [13:0] p;
        logic [13:0] q100;
        p    = y - 14'd1;
        q100 = 14'((32'(p) * 32'd5243) >> 19);
        return 24'(32'(p) * 32'd365) + 24'(p >> 2) - 24'(q100) + 24'(q100 >> 2);
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/cda_ctrl.sv */
// Sequencing state machine of the date unit.
`default_nettype none
module cda_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_accept,
    input  cda_pkg::t_stat i_stat,
    output logic           o_ready,
    output cda_pkg::t_ctrl o_ctrl
);

    cda_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cda_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cda_pkg::ST_IDLE: begin
                if (i_accept) n_state = cda_pkg::ST_CHECK;
            end
            cda_pkg::ST_CHECK: begin
                if (!i_stat.chk_ok) n_state = cda_pkg::ST_FINISH;
                else if (i_stat.mode == cda_pkg::MODE_DATE) n_state = cda_pkg::ST_SPLIT;
                else n_state = cda_pkg::ST_DOY;
            end
            cda_pkg::ST_DOY: begin
                if (i_stat.doy_done) begin
                    case (i_stat.mode)
                        cda_pkg::MODE_ADD:  n_state = cda_pkg::ST_ADD;
                        cda_pkg::MODE_DIFF: n_state = cda_pkg::ST_SERIAL;
                        default:            n_state = cda_pkg::ST_FINISH;
                    endcase
                end
            end
            cda_pkg::ST_ADD:   n_state = cda_pkg::ST_YEARS;
            cda_pkg::ST_YEARS: begin
                if (i_stat.year_done) begin
                    n_state = i_stat.year_over ? cda_pkg::ST_FINISH : cda_pkg::ST_SPLIT_INIT;
                end
            end
            cda_pkg::ST_SPLIT_INIT: n_state = cda_pkg::ST_SPLIT;
            cda_pkg::ST_SPLIT: begin
                if (i_stat.split_done) n_state = cda_pkg::ST_FINISH;
            end
            cda_pkg::ST_SERIAL: begin
                n_state = i_stat.second ? cda_pkg::ST_FINISH : cda_pkg::ST_SAVE_A;
            end
            cda_pkg::ST_SAVE_A: n_state = cda_pkg::ST_CHECK;
            cda_pkg::ST_FINISH: begin
                if (i_stat.out_free) n_state = cda_pkg::ST_IDLE;
            end
            default: n_state = cda_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ready     = 1'b0;
        o_ctrl.cmd  = cda_pkg::CMD_NONE;
        case (r_state)
            cda_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_accept) o_ctrl.cmd = cda_pkg::CMD_LOAD;
            end
            cda_pkg::ST_CHECK: o_ctrl.cmd = cda_pkg::CMD_CHECK;
            cda_pkg::ST_DOY: begin
                if (!i_stat.doy_done) o_ctrl.cmd = cda_pkg::CMD_DOY_STEP;
            end
            cda_pkg::ST_ADD: o_ctrl.cmd = cda_pkg::CMD_ADD_CNT;
            cda_pkg::ST_YEARS: begin
                if (!i_stat.year_done) o_ctrl.cmd = cda_pkg::CMD_YEAR_STEP;
            end
            cda_pkg::ST_SPLIT_INIT: o_ctrl.cmd = cda_pkg::CMD_SPLIT_INIT;
            cda_pkg::ST_SPLIT: begin
                if (!i_stat.split_done) o_ctrl.cmd = cda_pkg::CMD_SPLIT_STEP;
            end
            cda_pkg::ST_SERIAL: o_ctrl.cmd = cda_pkg::CMD_SERIAL;
            cda_pkg::ST_SAVE_A: o_ctrl.cmd = cda_pkg::CMD_SAVE_A;
            cda_pkg::ST_FINISH: begin
                if (i_stat.out_free) o_ctrl.cmd = cda_pkg::CMD_FINISH;
            end
            default: o_ctrl.cmd = cda_pkg::CMD_NONE;
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/cda_dp.sv */
// Datapath of the date unit: working date, accumulator and result register.
`default_nettype none
module cda_dp #(
    parameter int unsigned YEAR_LIMIT = 9999
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  cda_pkg::t_ctrl i_ctrl,
    input  wire  [1:0]     i_mode,
    input  wire  [13:0]    i_first_year,
    input  wire  [3:0]     i_first_month,
    input  wire  [4:0]     i_first_day,
    input  wire  [13:0]    i_second_year,
    input  wire  [3:0]     i_second_month,
    input  wire  [4:0]     i_second_day,
    input  wire  [13:0]    i_day_count_in,
    input  wire            i_include_end_day,
    input  wire            i_out_ready,
    output cda_pkg::t_stat o_stat,
    output logic           o_out_valid,
    output logic [13:0]    o_result_year,
    output logic [3:0]     o_result_month,
    output logic [4:0]     o_result_day,
    output logic [22:0]    o_day_count_out,
    output logic           o_bad_input
);

    localparam logic [14:0] YEAR_BOUND =
        15'((YEAR_LIMIT > cda_pkg::YEAR_FIELD_MAX) ? cda_pkg::YEAR_FIELD_MAX : YEAR_LIMIT);

    logic [1:0]  r_mode;
    logic [13:0] r_cnt, r_y2;
    logic [3:0]  r_m2;
    logic [4:0]  r_d2;
    logic        r_end;
    logic [14:0] r_y;
    logic [3:0]  r_m, r_i;
    logic [4:0]  r_d;
    logic [23:0] r_acc, r_sa;
    logic        r_bad, r_second, r_ovalid;

    logic [4:0]  w_dim_i;
    logic [8:0]  w_diy;
    logic        w_date_ok, w_order_ok, w_over;
    logic [23:0] w_mag0, w_mag;
    logic        w_neg, w_sat;
    logic [22:0] w_magc;

    // Calendar lookups on the working date
    assign w_dim_i    = cda_pkg::days_in_month(r_i, r_y);
    assign w_diy      = cda_pkg::days_in_year(r_y);
    assign w_date_ok  = (r_y >= 15'd1) && (r_y <= YEAR_BOUND) && (r_d >= 5'd1)
                        && (r_d <= cda_pkg::days_in_month(r_m, r_y));
    assign w_order_ok = (r_y >= 15'd1) && (r_y <= YEAR_BOUND) && (r_acc >= 24'd1)
                        && (r_acc <= 24'(w_diy));
    assign w_over     = r_y > YEAR_BOUND;

    // Difference magnitude and saturation
    assign w_neg  = !(r_sa < r_acc);
    assign w_mag0 = w_neg ? (r_sa - r_acc) : (r_acc - r_sa);
    assign w_mag  = w_mag0 + 24'(r_end);
    assign w_sat  = w_mag > cda_pkg::COUNT_MAX;
    assign w_magc = w_sat ? cda_pkg::COUNT_MAX[22:0] : w_mag[22:0];

    // Status towards the controller
    always_comb begin
        o_stat.mode       = r_mode;
        o_stat.chk_ok     = (r_mode == cda_pkg::MODE_DATE) ? w_order_ok : w_date_ok;
        o_stat.doy_done   = r_i >= r_m;
        o_stat.year_done  = (r_acc <= 24'(w_diy)) || w_over;
        o_stat.year_over  = w_over;
        o_stat.split_done = (r_i >= 4'd12) || (r_acc <= 24'(w_dim_i));
        o_stat.second     = r_second;
        o_stat.out_free   = !r_ovalid || i_out_ready;
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (i_ctrl.cmd)
            cda_pkg::CMD_LOAD: begin
                r_mode   <= i_mode;
                r_cnt    <= i_day_count_in;
                r_y2     <= i_second_year;
                r_m2     <= i_second_month;
                r_d2     <= i_second_day;
                r_end    <= i_include_end_day;
                r_y      <= {1'b0, i_first_year};
                r_m      <= i_first_month;
                r_d      <= i_first_day;
                r_i      <= 4'd1;
                r_acc    <= (i_mode == cda_pkg::MODE_DATE) ? 24'(i_day_count_in)
                                                           : 24'(i_first_day);
                r_bad    <= 1'b0;
                r_second <= 1'b0;
            end
            cda_pkg::CMD_CHECK: begin
                r_bad <= r_bad | !o_stat.chk_ok;
            end
            cda_pkg::CMD_DOY_STEP: begin
                r_acc <= r_acc + 24'(w_dim_i);
                r_i   <= r_i + 4'd1;
            end
            cda_pkg::CMD_ADD_CNT: begin
                r_acc <= r_acc + 24'(r_cnt);
            end
            cda_pkg::CMD_YEAR_STEP: begin
                r_acc <= r_acc - 24'(w_diy);
                r_y   <= r_y + 15'd1;
            end
            cda_pkg::CMD_SPLIT_INIT: begin
                r_i <= 4'd1;
            end
            cda_pkg::CMD_SPLIT_STEP: begin
                r_acc <= r_acc - 24'(w_dim_i);
                r_i   <= r_i + 4'd1;
            end
            cda_pkg::CMD_SERIAL: begin
                r_acc <= r_acc + cda_pkg::serial_base(r_y[13:0]);
            end
            cda_pkg::CMD_SAVE_A: begin
                r_sa     <= r_acc;
                r_y      <= {1'b0, r_y2};
                r_m      <= r_m2;
                r_d      <= r_d2;
                r_i      <= 4'd1;
                r_acc    <= 24'(r_d2);
                r_second <= 1'b1;
            end
            default: ;
        endcase
    end

    // Result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctrl.cmd == cda_pkg::CMD_FINISH) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmd == cda_pkg::CMD_FINISH) begin
            o_result_year   <= 14'd0;
            o_result_month  <= 4'd0;
            o_result_day    <= 5'd0;
            o_day_count_out <= 23'd0;
            case (r_mode)
                cda_pkg::MODE_DIFF: begin
                    o_bad_input <= r_bad | w_sat;
                    if (!r_bad) o_day_count_out <= w_neg ? (23'd0 - w_magc) : w_magc;
                end
                cda_pkg::MODE_DOY: begin
                    o_bad_input <= r_bad;
                    if (!r_bad) o_day_count_out <= r_acc[22:0];
                end
                default: begin
                    o_bad_input <= r_bad | ((r_mode == cda_pkg::MODE_ADD) && w_over);
                    if (!(r_bad || ((r_mode == cda_pkg::MODE_ADD) && w_over))) begin
                        o_result_year  <= r_y[13:0];
                        o_result_month <= r_i;
                        o_result_day   <= r_acc[4:0];
                    end
                end
            endcase
        end
    end

    assign o_out_valid = r_ovalid;

endmodule
`default_nettype wire

/* hw/rtl/calendar_date_arithmetic.sv */
// Top level of the Gregorian date unit: stream ports, controller and datapath.
`default_nettype none
// One request beat gives one result beat. A request takes its walk through
// the calendar one step a cycle: month steps (up to 11) for the day of year,
// year steps (up to about 45) and month steps (up to 11) for adding days, two
// date passes for the difference. A request rejected at the first check skips
// the walk, and for the others the time is set by that month and year walk
// in the datapath; the next request is taken once the result is in the
// output register, which may still wait.
module calendar_date_arithmetic #(
    parameter int unsigned YEAR_LIMIT = 9999
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // first_year, first_month, first_day, second_year, second_month,
    // second_day, day_count_in, include_end_day, zero pad
    input  wire  [63:0] s_tdata,
    // mode
    input  wire  [1:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // result_year, result_month, result_day, day_count_out, zero pad
    output logic [47:0] m_tdata,
    // bad_input
    output logic        m_tuser
);

    cda_pkg::t_ctrl w_ctrl;
    cda_pkg::t_stat w_stat;
    logic [13:0] w_ry;
    logic [3:0]  w_rm;
    logic [4:0]  w_rd;
    logic [22:0] w_cnt;

    cda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_tvalid && s_tready),
        .i_stat   (w_stat),
        .o_ready  (s_tready),
        .o_ctrl   (w_ctrl)
    );

    cda_dp #(.YEAR_LIMIT(YEAR_LIMIT)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (w_ctrl),
        .i_mode            (s_tuser),
        .i_first_year      (s_tdata[13:0]),
        .i_first_month     (s_tdata[17:14]),
        .i_first_day       (s_tdata[22:18]),
        .i_second_year     (s_tdata[36:23]),
        .i_second_month    (s_tdata[40:37]),
        .i_second_day      (s_tdata[45:41]),
        .i_day_count_in    (s_tdata[59:46]),
        .i_include_end_day (s_tdata[60]),
        .i_out_ready       (m_tready),
        .o_stat            (w_stat),
        .o_out_valid       (m_tvalid),
        .o_result_year     (w_ry),
        .o_result_month    (w_rm),
        .o_result_day      (w_rd),
        .o_day_count_out   (w_cnt),
        .o_bad_input       (m_tuser)
    );

    assign m_tdata = {2'b00, w_cnt, w_rd, w_rm, w_ry};

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench of the Gregorian date unit: driver, monitor and date predictor.
module tb_top;

    localparam int unsigned YEAR_BOUND = 9999;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned N_RANDOM = 1800;

    typedef struct packed {
        logic [1:0]  mode;
        logic [13:0] y1;
        logic [3:0]  m1;
        logic [4:0]  d1;
        logic [13:0] y2;
        logic [3:0]  m2;
        logic [4:0]  d2;
        logic [13:0] cnt;
        logic        end_day;
    } t_req;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [22:0] count;
        logic        bad;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    wire         s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    wire         m_tvalid;
    logic        m_tready;
    wire  [47:0] m_tdata;
    wire         m_tuser;

    t_req pending_reqs[$];
    t_res expected_dates[$];
    int   mismatch_count;
    int   idle_cycles;
    bit   stim_done;
    int   burst_left;
    int   gap_left;
    int   stall_phase;

    calendar_date_arithmetic u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Calendar helpers for the predictor
    function automatic bit leap_year(int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned month_days(int unsigned m, int unsigned y);
        int unsigned lens[12];
        lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m < 1 || m > 12) return 0;
        if (m == 2) return leap_year(y) ? 29 : 28;
        return lens[m - 1];
    endfunction

    function automatic int unsigned year_days(int unsigned y);
        return leap_year(y) ? 366 : 365;
    endfunction

    function automatic bit date_valid(int unsigned y, int unsigned m, int unsigned d);
        return y >= 1 && y <= YEAR_BOUND && m >= 1 && m <= 12 && d >= 1 &&
               d <= month_days(m, y);
    endfunction

    function automatic int unsigned ordinal_day(int unsigned y, int unsigned m, int unsigned d);
        int unsigned total;
        total = d;
        for (int unsigned i = 1; i < m; i++) total += month_days(i, y);
        return total;
    endfunction

    function automatic int unsigned day_number(int unsigned y, int unsigned m, int unsigned d);
        int unsigned p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400 + ordinal_day(y, m, d);
    endfunction

    // Expected result of one request
    function automatic t_res predict_date(t_req r);
        t_res        res;
        int unsigned rem, y, mon, a, b, mag;
        bit          neg;
        res = '0;
        case (r.mode)
            cda_pkg::MODE_ADD: begin
                if (!date_valid(r.y1, r.m1, r.d1)) res.bad = 1'b1;
                else begin
                    rem = ordinal_day(r.y1, r.m1, r.d1) + r.cnt;
                    y = r.y1;
                    while (rem > year_days(y)) begin
                        rem -= year_days(y);
                        y++;
                    end
                    if (y > YEAR_BOUND) res.bad = 1'b1;
                    else begin
                        mon = 1;
                        while (mon < 12 && rem > month_days(mon, y)) begin
                            rem -= month_days(mon, y);
                            mon++;
                        end
                        res.year = 14'(y); res.month = 4'(mon); res.day = 5'(rem);
                    end
                end
            end
            cda_pkg::MODE_DIFF: begin
                if (!date_valid(r.y1, r.m1, r.d1) || !date_valid(r.y2, r.m2, r.d2))
                    res.bad = 1'b1;
                else begin
                    a = day_number(r.y1, r.m1, r.d1);
                    b = day_number(r.y2, r.m2, r.d2);
                    neg = !(a < b);
                    mag = neg ? a - b : b - a;
                    if (r.end_day) mag++;
                    res.count = neg ? 23'(-mag) : 23'(mag);
                end
            end
            cda_pkg::MODE_DOY: begin
                if (!date_valid(r.y1, r.m1, r.d1)) res.bad = 1'b1;
                else res.count = 23'(ordinal_day(r.y1, r.m1, r.d1));
            end
            default: begin
                if (r.y1 < 1 || r.y1 > YEAR_BOUND || r.cnt < 1 || r.cnt > year_days(r.y1))
                    res.bad = 1'b1;
                else begin
                    rem = r.cnt;
                    mon = 1;
                    while (mon < 12 && rem > month_days(mon, r.y1)) begin
                        rem -= month_days(mon, r.y1);
                        mon++;
                    end
                    res.year = r.y1; res.month = 4'(mon); res.day = 5'(rem);
                end
            end
        endcase
        return res;
    endfunction

    function automatic t_req make_req(logic [1:0] mode, int y1, int m1, int d1, int y2,
                                      int m2, int d2, int cnt, bit e);
        t_req r;
        r.mode = mode; r.y1 = 14'(y1); r.m1 = 4'(m1); r.d1 = 5'(d1); r.y2 = 14'(y2);
        r.m2 = 4'(m2); r.d2 = 5'(d2); r.cnt = 14'(cnt); r.end_day = e;
        return r;
    endfunction

    // Mostly valid dates, occasionally raw field noise
    function automatic t_req random_req();
        t_req r;
        r = t_req'(63'({$urandom, $urandom}));
        r.mode = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 9) != 0) begin
            r.y1 = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(9950, 9999)) :
                   14'($urandom_range(1, 9999));
            r.m1 = 4'($urandom_range(1, 12));
            r.d1 = 5'($urandom_range(1, month_days(r.m1, r.y1)));
            r.y2 = ($urandom_range(0, 1) == 0) ? 14'(r.y1 + $urandom_range(0, 2) - 1) :
                   14'($urandom_range(1, 9999));
            if (r.y2 < 1 || r.y2 > 9999) r.y2 = r.y1;
            r.m2 = 4'($urandom_range(1, 12));
            r.d2 = 5'($urandom_range(1, month_days(r.m2, r.y2)));
            if (r.mode == cda_pkg::MODE_DATE && $urandom_range(0, 3) != 0)
                r.cnt = 14'($urandom_range(1, year_days(r.y1)));
        end
        return r;
    endfunction

    // Stimulus
    initial begin
        pending_reqs.push_back(make_req(cda_pkg::MODE_ADD, 1, 1, 1, 1, 1, 1, 0, 0));
        pending_reqs.push_back(make_req(cda_pkg::MODE_ADD, 9999, 12, 31, 1, 1, 1, 1, 0));
        pending_reqs.push_back(make_req(cda_pkg::MODE_ADD, 9999, 12, 31, 1, 1, 1, 0, 1));
        pending_reqs.push_back(make_req(cda_pkg::MODE_ADD, 2000, 2, 28, 1, 1, 1, 16383, 0));
        pending_reqs.push_back(make_req(cda_pkg::MODE_ADD, 1900, 2, 29, 1, 1, 1, 5, 0));
        pending_reqs.push_back(make_req(cda_pkg::MODE_ADD, 0, 13, 0, 1, 1, 1, 5, 0));
        pending_reqs.push_back(make_req(cda_pkg::MODE_DIFF, 1, 1, 1, 9999, 12, 31, 0, 1));
        pending_reqs.push_back(make_req(cda_pkg::MODE_DIFF, 9999, 12, 31, 1, 1, 1, 0, 0));
        pending_reqs.push_back(make_req(cda_pkg::MODE_DIFF, 2024, 3, 1, 2024, 3, 1, 0, 0));
        pending_reqs.push_back(make_req(cda_pkg::MODE_DIFF, 2024, 3, 1, 2024, 3, 1, 0, 1));
        pending_reqs.push_back(make_req(cda_pkg::MODE_DIFF, 2024, 3, 1, 16383, 15, 31, 0, 0));
        pending_reqs.push_back(make_req(cda_pkg::MODE_DOY, 2000, 12, 31, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(cda_pkg::MODE_DOY, 2100, 2, 29, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(cda_pkg::MODE_DOY, 10000, 1, 1, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(cda_pkg::MODE_DATE, 2000, 0, 0, 0, 0, 0, 366, 0));
        pending_reqs.push_back(make_req(cda_pkg::MODE_DATE, 2001, 0, 0, 0, 0, 0, 366, 0));
        pending_reqs.push_back(make_req(cda_pkg::MODE_DATE, 2001, 15, 31, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(cda_pkg::MODE_DATE, 1600, 0, 0, 0, 0, 0, 60, 0));
        pending_reqs.push_back(make_req(cda_pkg::MODE_DATE, 0, 0, 0, 0, 0, 0, 1, 0));
        pending_reqs.push_back(make_req(cda_pkg::MODE_DATE, 9999, 0, 0, 16383, 15, 31,
                                        16383, 1));
        for (int i = 0; i < N_RANDOM; i++) pending_reqs.push_back(random_req());
        stim_done = 1'b1;
    end

    // Reset, end of run
    initial begin
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && pending_reqs.size() == 0 && !s_tvalid &&
              expected_dates.size() == 0);
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    // Driver: bursts and gaps
    initial begin
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
        burst_left = 0; gap_left = 0; stall_phase = 0;
        mismatch_count = 0; idle_cycles = 0;
    end

    always @(posedge i_clk) begin
        t_req r;
        if (i_rst_n) begin
            if (!s_tvalid || s_tready) begin
                if (s_tvalid) expected_dates.push_back(predict_date(t_req'({
                    s_tuser, s_tdata[13:0], s_tdata[17:14], s_tdata[22:18],
                    s_tdata[36:23], s_tdata[40:37], s_tdata[45:41], s_tdata[59:46],
                    s_tdata[60]})));
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    r = pending_reqs.pop_front();
                    s_tdata  <= {3'b0, r.end_day, r.cnt, r.d2, r.m2, r.y2, r.d1, r.m1, r.y1};
                    s_tuser  <= r.mode;
                    s_tvalid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end else burst_left <= burst_left - 1;
                end else s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern and monitor
    always @(posedge i_clk) begin
        t_res got, exp_res;
        if (i_rst_n) begin
            stall_phase <= stall_phase + 1;
            m_tready <= (stall_phase[9:8] == 2'd0) ? 1'b1 :
                        (stall_phase[2:0] != 3'd5 && $urandom_range(0, 3) != 0);
            idle_cycles <= ((s_tvalid && s_tready) || (m_tvalid && m_tready)) ? 0 :
                           idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[13:0], m_tdata[17:14], m_tdata[22:18], m_tdata[45:23], m_tuser};
                if (expected_dates.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10) $display("unexpected result beat %h", got);
                end else begin
                    exp_res = expected_dates.pop_front();
                    if (got !== exp_res) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                            $display(
                    "mismatch: exp y%0d m%0d d%0d c%0d b%0b got y%0d m%0d d%0d c%0d b%0b",
                                     exp_res.year, exp_res.month, exp_res.day,
                                     $signed(exp_res.count), exp_res.bad, got.year, got.month,
                                     got.day, $signed(got.count), got.bad);
                    end
                end
            end
        end
    end
endmodule
